// File: rtl/grayscale_bilateral_filter_assert.svh
// Assertion macros shared by the bilateral filter checker.
// Depends on nothing; included by the checker file.
`ifndef GRAYSCALE_BILATERAL_FILTER_ASSERT_SVH
`define GRAYSCALE_BILATERAL_FILTER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define GBF_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");
// Next-cycle implication checked outside reset.
`define GBF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");
`endif

// File: rtl/gbf_pkg.sv
// Package for the grayscale bilateral filter: sizes, opcodes and states.
// Depends on nothing; used by the top level and the checker.
package gbf_pkg;

  localparam int MaxWidthDefault  = 256;
  localparam int MaxHeightDefault = 256;
  localparam int MaxRadiusDefault = 7;
  localparam int MaxTapsDefault   = 225;

  localparam int PixW    = 8;
  localparam int WeightW = 17;
  localparam logic [WeightW-1:0] WeightOne = 17'd65536;

  localparam logic [8:0] ResetWidth  = 9'd256;
  localparam logic [8:0] ResetHeight = 9'd256;
  localparam logic [2:0] ResetRadius = 3'd2;

  typedef enum logic [1:0] {
    OP_WRITE_PIXEL  = 2'd0,
    OP_LOAD_COLOR   = 2'd1,
    OP_LOAD_SPACE   = 2'd2,
    OP_FILTER       = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_RADIUS = 2'd2
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CENTER,
    ST_CENTER_WAIT,
    ST_TAP,
    ST_PIX_WAIT,
    ST_COLOR_WAIT,
    ST_MUL_W,
    ST_MUL_P,
    ST_DIV,
    ST_DONE
  } state_t;

  function automatic logic [WeightW-1:0] sat_weight(input logic [WeightW-1:0] v);
    return (v > WeightOne) ? WeightOne : v;
  endfunction

endpackage

// File: rtl/gbf_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module gbf_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/grayscale_bilateral_filter.sv
// Grayscale bilateral filter: top level with frame, weight tables and sequencer.
// Depends on gbf_pkg and gbf_ram.
//
// Each word accepted on start (when busy is low) writes one frame pixel, loads
// one intensity-difference weight, loads one disc-ordered spatial weight, or
// requests one filtered pixel. Writes and loads complete at the accepting edge,
// so busy stays low and the next word can follow on the very next edge. A filter
// request walks every offset of the (2r+1)^2 square in row order; offsets
// outside the disc are only stepped over, and taps inside it go through a frame
// read, a color table read, a weight multiply and a weighted-pixel multiply with
// accumulate, all through one shared multiplier. A restoring divider then
// produces the quotient one bit per cycle; a zero weight sum ends the division
// after its first step. The next word is taken in the cycle after done. The
// result is shown on filtered_value for exactly one cycle with done high; the
// receiver cannot stall it. Border pixels reflect without repeating the edge,
// and a zero weight sum returns the center pixel.
module grayscale_bilateral_filter (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                opcode,
  input  logic [7:0]                row,
  input  logic [7:0]                column,
  input  logic [gbf_pkg::PixW-1:0]  pixel_value,
  input  logic [7:0]                table_index,
  input  logic [gbf_pkg::WeightW-1:0] weight_value,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [8:0]                cfg_data,
  output logic                      done,
  output logic [gbf_pkg::PixW-1:0]  filtered_value
);
  // The port and register widths fix the frame and table sizes, so they are
  // taken straight from the package.
  localparam int MaxWidth  = gbf_pkg::MaxWidthDefault;
  localparam int MaxHeight = gbf_pkg::MaxHeightDefault;
  localparam int MaxRadius = gbf_pkg::MaxRadiusDefault;
  localparam int MaxTaps   = gbf_pkg::MaxTapsDefault;

  localparam int XW = $clog2(MaxWidth);
  localparam int YW = $clog2(MaxHeight);
  localparam int AW = XW + YW;
  localparam int TW = $clog2(MaxTaps);
  localparam int CW = 14;  // signed coordinate width, covers +-2*4096
  localparam int AccW = 64;

  // Configuration registers.
  logic [8:0] image_width, image_height;
  logic [2:0] filter_radius;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= gbf_pkg::ResetWidth;
      image_height  <= gbf_pkg::ResetHeight;
      filter_radius <= gbf_pkg::ResetRadius;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        gbf_pkg::REG_WIDTH:  image_width   <= cfg_data;
        gbf_pkg::REG_HEIGHT: image_height  <= cfg_data;
        gbf_pkg::REG_RADIUS: filter_radius <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Effective (clamped) sizes.
  logic signed [CW-1:0] w_eff, h_eff, r_eff;
  always_comb begin
    w_eff = (image_width == 9'd0) ? CW'(1) :
            (int'(image_width) > MaxWidth) ? CW'(MaxWidth) : CW'(image_width);
    h_eff = (image_height == 9'd0) ? CW'(1) :
            (int'(image_height) > MaxHeight) ? CW'(MaxHeight) : CW'(image_height);
    r_eff = (filter_radius == 3'd0) ? CW'(1) :
            (int'(filter_radius) > MaxRadius) ? CW'(MaxRadius) : CW'(filter_radius);
  end

  gbf_pkg::state_t state, state_next;
  logic accept;
  assign accept = start && (state == gbf_pkg::ST_IDLE);
  assign busy = (state != gbf_pkg::ST_IDLE);

  // Working registers.
  logic signed [CW-1:0] cy, cx, dy, dx;
  logic [TW:0]          k;
  logic [7:0]           center, pix;
  logic [AccW-1:0]      acc, wsum, rem;
  logic [33:0]          wt;
  logic [3:0]           dcnt;
  logic [7:0]           quot;

  // Store ports.
  logic                 frame_we, color_we, space_we;
  logic [AW-1:0]        frame_waddr, frame_raddr;
  logic [7:0]           frame_rdata;
  logic [16:0]          color_rdata, space_rdata;
  logic [7:0]           color_raddr;

  gbf_ram #(.Width(8), .Depth(MaxWidth*MaxHeight)) u_frame (
    .clk, .we(frame_we), .waddr(frame_waddr), .wdata(pixel_value),
    .raddr(frame_raddr), .rdata(frame_rdata));
  gbf_ram #(.Width(17), .Depth(256)) u_color (
    .clk, .we(color_we), .waddr(table_index),
    .wdata(gbf_pkg::sat_weight(weight_value)), .raddr(color_raddr),
    .rdata(color_rdata));
  gbf_ram #(.Width(17), .Depth(MaxTaps)) u_space (
    .clk, .we(space_we), .waddr(table_index[TW-1:0]),
    .wdata(gbf_pkg::sat_weight(weight_value)), .raddr(k[TW-1:0]),
    .rdata(space_rdata));

  assign frame_we = accept && (opcode == gbf_pkg::OP_WRITE_PIXEL)
                    && (CW'(row) < h_eff) && (CW'(column) < w_eff);
  assign frame_waddr = {row[YW-1:0], column[XW-1:0]};
  assign color_we = accept && (opcode == gbf_pkg::OP_LOAD_COLOR);
  assign space_we = accept && (opcode == gbf_pkg::OP_LOAD_SPACE)
                    && (int'(table_index) < MaxTaps);

  // Reflection of neighbor coordinates.
  function automatic logic signed [CW-1:0] reflect(input logic signed [CW-1:0] x,
                                                   input logic signed [CW-1:0] n);
    logic signed [CW-1:0] v;
    v = (x < 0) ? -x : x;
    if (v >= n) v = (n <<< 1) - CW'(2) - v;
    if (v < 0) v = '0;
    if (v > n - CW'(1)) v = n - CW'(1);
    return v;
  endfunction

  logic signed [CW-1:0] ny, nx;
  logic in_disc;
  assign ny = reflect(cy + dy, h_eff);
  assign nx = reflect(cx + dx, w_eff);
  assign in_disc = (dy*dy + dx*dx <= r_eff*r_eff) && (int'(k) < MaxTaps);

  always_comb begin
    if (state == gbf_pkg::ST_CENTER) frame_raddr = {cy[YW-1:0], cx[XW-1:0]};
    else frame_raddr = {ny[YW-1:0], nx[XW-1:0]};
  end

  logic [7:0] diff;
  assign diff = (frame_rdata > center) ? frame_rdata - center : center - frame_rdata;
  assign color_raddr = diff;

  // Shared multiplier: space*color, then weight*pixel.
  logic [33:0] mul_a;
  logic [16:0] mul_b;
  logic [50:0] mul_y;
  always_comb begin
    if (state == gbf_pkg::ST_MUL_W) begin
      mul_a = 34'(space_rdata);
      mul_b = color_rdata;
    end else begin
      mul_a = wt;
      mul_b = 17'(pix);
    end
    mul_y = mul_a * mul_b;
  end

  // Restoring divider step: quotient below 256, so 8 steps.
  logic [AccW:0] trial;
  assign trial = {1'b0, rem} - ({1'b0, wsum} << dcnt[2:0]);

  logic last_dx, last_dy;
  assign last_dx = (dx == r_eff);
  assign last_dy = (dy == r_eff);

  always_comb begin
    state_next = state;
    unique case (state)
      gbf_pkg::ST_IDLE:
        if (accept && opcode == gbf_pkg::OP_FILTER) state_next = gbf_pkg::ST_CENTER;
      gbf_pkg::ST_CENTER:      state_next = gbf_pkg::ST_CENTER_WAIT;
      gbf_pkg::ST_CENTER_WAIT: state_next = gbf_pkg::ST_TAP;
      gbf_pkg::ST_TAP:
        if (in_disc) state_next = gbf_pkg::ST_PIX_WAIT;
        else if (last_dx && last_dy) state_next = gbf_pkg::ST_DIV;
      gbf_pkg::ST_PIX_WAIT:    state_next = gbf_pkg::ST_COLOR_WAIT;
      gbf_pkg::ST_COLOR_WAIT:  state_next = gbf_pkg::ST_MUL_W;
      gbf_pkg::ST_MUL_W:       state_next = gbf_pkg::ST_MUL_P;
      gbf_pkg::ST_MUL_P:
        state_next = (last_dx && last_dy) ? gbf_pkg::ST_DIV : gbf_pkg::ST_TAP;
      gbf_pkg::ST_DIV:
        if (wsum == '0 || dcnt == 4'd0) state_next = gbf_pkg::ST_DONE;
      gbf_pkg::ST_DONE:        state_next = gbf_pkg::ST_IDLE;
      default:                 state_next = gbf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= gbf_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      gbf_pkg::ST_IDLE: begin
        cy <= (CW'(row) > h_eff - CW'(1)) ? h_eff - CW'(1) : CW'(row);
        cx <= (CW'(column) > w_eff - CW'(1)) ? w_eff - CW'(1) : CW'(column);
        dy <= -r_eff;
        dx <= -r_eff;
        k <= '0;
        acc <= '0;
        wsum <= '0;
        quot <= '0;
        dcnt <= 4'd7;
      end
      gbf_pkg::ST_CENTER_WAIT: center <= frame_rdata;
      gbf_pkg::ST_TAP:
        if (!in_disc) begin
          dx <= last_dx ? -r_eff : dx + CW'(1);
          if (last_dx) dy <= dy + CW'(1);
        end
      gbf_pkg::ST_COLOR_WAIT: pix <= frame_rdata;
      gbf_pkg::ST_MUL_W: wt <= mul_y[33:0];
      gbf_pkg::ST_MUL_P: begin
        acc  <= acc + AccW'(mul_y);
        wsum <= wsum + AccW'(wt);
        k    <= k + 1'b1;
        dx   <= last_dx ? -r_eff : dx + CW'(1);
        if (last_dx) dy <= dy + CW'(1);
        rem  <= acc + AccW'(mul_y);
      end
      gbf_pkg::ST_DIV: begin
        if (!trial[AccW]) begin
          rem <= trial[AccW-1:0];
          quot[dcnt[2:0]] <= 1'b1;
        end
        dcnt <= dcnt - 1'b1;
      end
      default: ;
    endcase
  end

  // Note the pixel-wait state reads the tap neighbor; center wait reads center.
  always_comb begin
    done = (state == gbf_pkg::ST_DONE);
    filtered_value = (wsum == '0) ? center : quot;
  end
endmodule

// File: rtl/gbf_checker.sv
// Port-level checker for the grayscale bilateral filter, bound to the top level.
// Depends on gbf_pkg and the assertion macro header.
`include "grayscale_bilateral_filter_assert.svh"
module gbf_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic [1:0] opcode,
  input logic done
);
  `GBF_ASSERT_IMP(a_done_busy, clk, rst, done, busy)
  `GBF_ASSERT_NEXT(a_done_single, clk, rst, done, !done)
  `GBF_ASSERT_NEXT(a_filter_busy, clk, rst,
    start && !busy && opcode == gbf_pkg::OP_FILTER, busy && !done)
endmodule

bind grayscale_bilateral_filter gbf_checker u_gbf_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode), .done(done));
